// ===== rtl/ssfr_pkg.sv =====
package ssfr_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned LenW          = 16;
  localparam int unsigned TickW         = 17;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] FrameMagic   = 32'h4C45_444D;
  localparam logic [WordW-1:0] CodePrepare  = 32'h0000_0001;
  localparam logic [WordW-1:0] CodeStatus   = 32'h0000_0002;
  localparam logic [LenW-1:0]  MaxFrameWords = 16'hFFFF;
  localparam logic [LenW-1:0]  CounterMax    = 16'hFFFF;
  localparam logic [TickW-1:0] TicksMax      = 17'h1_FFFF;
  localparam logic [LenW-1:0]  FrameLenReset = 16'd4096;
  localparam logic [LenW-1:0]  TimeoutReset  = 16'd200;

  // input command codes
  localparam logic [1:0] CmdWord   = 2'd0;
  localparam logic [1:0] CmdTick   = 2'd1;
  localparam logic [1:0] CmdBusErr = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFrameLen = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 1'd1;

  typedef enum logic [1:0] {
    StReady = 2'd0,
    StBusy  = 2'd1,
    StDone  = 2'd2,
    StError = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OpWord   = 2'd0,
    OpTick   = 2'd1,
    OpBusErr = 2'd2,
    OpNone   = 2'd3
  } op_e;

  // header command kind, latched from the second header word
  typedef enum logic [1:0] {
    KindUnknown = 2'd0,
    KindPrepare = 2'd1,
    KindStatus  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [WordW-1:0] rx_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       reply_status;
    logic             data_valid;
    logic [WordW-1:0] data_word;
    logic [LenW-1:0]  data_index;
    logic             frame_done;
    logic             in_data_phase;
    logic [1:0]       status_now;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] word;
  } entry_t;

endpackage

// ===== rtl/ssfr_front.sv =====
module ssfr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssfr_pkg::in_item_t in_item_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ssfr_pkg::entry_t   push_entry_o
);

  logic             valid_q;
  ssfr_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d.word = in_item_i.rx_word;
    unique case (in_item_i.command)
      ssfr_pkg::CmdWord:   entry_d.op = ssfr_pkg::OpWord;
      ssfr_pkg::CmdTick:   entry_d.op = ssfr_pkg::OpTick;
      ssfr_pkg::CmdBusErr: entry_d.op = ssfr_pkg::OpBusErr;
      default:             entry_d.op = ssfr_pkg::OpNone;
    endcase
  end

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== rtl/ssfr_queue.sv =====
module ssfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ssfr_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ssfr_pkg::entry_t pop_entry_o
);

  ssfr_pkg::entry_t                     mem_q [ssfr_pkg::QueueDepth];
  logic [ssfr_pkg::QueuePtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ssfr_pkg::QueueCntW-1:0]       count_q;
  logic                                 push, pop;

  assign push_ready_o = (count_q != ssfr_pkg::QueueCntW'(ssfr_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == ssfr_pkg::QueuePtrW'(ssfr_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == ssfr_pkg::QueuePtrW'(ssfr_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/ssfr_back.sv =====
module ssfr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ssfr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ssfr_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  ssfr_pkg::entry_t                   pop_entry_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ssfr_pkg::out_item_t                out_item_o
);

  typedef enum logic {
    PhCommand = 1'b0,
    PhData    = 1'b1
  } phase_e;

  logic [ssfr_pkg::LenW-1:0]  frame_len_q, timeout_q;
  phase_e                     phase_q, phase_d;
  logic [1:0]                 hdr_pos_q, hdr_pos_d;
  logic                       magic_q, magic_d;
  ssfr_pkg::kind_e            kind_q, kind_d;
  ssfr_pkg::status_e          link_q, link_d;
  ssfr_pkg::status_e          armed_q, armed_d;
  logic [ssfr_pkg::LenW-1:0]  wcnt_q, wcnt_d;
  logic [ssfr_pkg::TickW-1:0] ticks_q, ticks_d;
  logic                       out_valid_q;
  ssfr_pkg::out_item_t        out_item_q, out_item_d;

  logic [ssfr_pkg::LenW-1:0]  eff_len;
  logic [ssfr_pkg::LenW:0]    wcnt_next;
  logic                       pop;
  logic                       rearm;

  assign eff_len   = (frame_len_q > ssfr_pkg::MaxFrameWords) ? ssfr_pkg::MaxFrameWords
                                                             : frame_len_q;
  assign wcnt_next = {1'b0, wcnt_q} + 17'd1;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    magic_d   = magic_q;
    kind_d    = kind_q;
    link_d    = link_q;
    armed_d   = armed_q;
    wcnt_d    = wcnt_q;
    ticks_d   = ticks_q;
    rearm     = 1'b0;

    out_item_d = '0;

    unique case (pop_entry_i.op)
      ssfr_pkg::OpWord: begin
        if (phase_q == PhData) begin
          out_item_d.reply_status = link_q;
          out_item_d.data_valid   = 1'b1;
          out_item_d.data_word    = pop_entry_i.word;
          out_item_d.data_index   = wcnt_q;
          if (wcnt_next >= {1'b0, eff_len}) begin
            out_item_d.frame_done = 1'b1;
            link_d  = ssfr_pkg::StDone;
            phase_d = PhCommand;
            rearm   = 1'b1;
          end
          if (wcnt_q < ssfr_pkg::CounterMax) begin
            wcnt_d = wcnt_next[ssfr_pkg::LenW-1:0];
          end
        end else begin
          out_item_d.reply_status = armed_q;
          priority case (hdr_pos_q)
            2'd0: begin
              magic_d   = (pop_entry_i.word == ssfr_pkg::FrameMagic);
              hdr_pos_d = 2'd1;
            end
            2'd1: begin
              priority if (pop_entry_i.word == ssfr_pkg::CodePrepare) begin
                kind_d = ssfr_pkg::KindPrepare;
              end else if (pop_entry_i.word == ssfr_pkg::CodeStatus) begin
                kind_d = ssfr_pkg::KindStatus;
              end else begin
                kind_d = ssfr_pkg::KindUnknown;
              end
              hdr_pos_d = 2'd2;
            end
            default: begin
              // judge the complete header
              rearm = 1'b1;
              priority if (!magic_q) begin
                link_d = ssfr_pkg::StError;
              end else if (kind_q == ssfr_pkg::KindPrepare) begin
                if (link_q != ssfr_pkg::StBusy) begin
                  if (pop_entry_i.word != {16'd0, eff_len}) begin
                    link_d = ssfr_pkg::StError;
                  end else begin
                    link_d    = ssfr_pkg::StBusy;
                    phase_d   = PhData;
                    wcnt_d    = '0;
                    ticks_d   = '0;
                    hdr_pos_d = 2'd0;
                    rearm     = 1'b0;
                  end
                end
              end else if (kind_q == ssfr_pkg::KindStatus) begin
                if (link_q == ssfr_pkg::StDone) begin
                  link_d = ssfr_pkg::StReady;
                end
              end else begin
                link_d = ssfr_pkg::StError;
              end
            end
          endcase
        end
      end
      ssfr_pkg::OpTick: begin
        if (phase_q == PhData) begin
          if (ticks_q < ssfr_pkg::TicksMax) begin
            ticks_d = ticks_q + 1'b1;
          end
          if (ticks_d > {1'b0, timeout_q}) begin
            link_d  = ssfr_pkg::StError;
            phase_d = PhCommand;
            rearm   = 1'b1;
          end
        end
      end
      ssfr_pkg::OpBusErr: begin
        link_d  = ssfr_pkg::StError;
        phase_d = PhCommand;
        rearm   = 1'b1;
      end
      default: begin
      end
    endcase

    // restart the header transfer with the fresh status
    if (rearm) begin
      hdr_pos_d = 2'd0;
      armed_d   = link_d;
    end

    out_item_d.in_data_phase = (phase_d == PhData);
    out_item_d.status_now    = link_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= ssfr_pkg::FrameLenReset;
      timeout_q   <= ssfr_pkg::TimeoutReset;
      phase_q     <= PhCommand;
      hdr_pos_q   <= 2'd0;
      magic_q     <= 1'b0;
      kind_q      <= ssfr_pkg::KindUnknown;
      link_q      <= ssfr_pkg::StReady;
      armed_q     <= ssfr_pkg::StReady;
      wcnt_q      <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ssfr_pkg::RegFrameLen: frame_len_q <= cfg_wdata_i;
          ssfr_pkg::RegTimeout:  timeout_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (pop) begin
        phase_q    <= phase_d;
        hdr_pos_q  <= hdr_pos_d;
        magic_q    <= magic_d;
        kind_q     <= kind_d;
        link_q     <= link_d;
        armed_q    <= armed_d;
        wcnt_q     <= wcnt_d;
        ticks_q    <= ticks_d;
        out_item_q <= out_item_d;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

endmodule

// ===== rtl/spi_slave_frame_receiver.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------
// input    | in        | in_valid_i/in_ready_o  | in_item_i  (command, rx_word)
// output   | out       | out_valid_o/out_ready_i| out_item_o (reply, data, status)
// config   | in        | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled; each item gives
// one result, registered through the input register, two-entry queue and output register.
// Reset clears the link state to ready/command phase and loads the
// register defaults (frame length 4096, timeout 200).
// A stalled output fills the queue, then in_ready_o drops; no item is lost.
module spi_slave_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ssfr_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ssfr_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [ssfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssfr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic             push_valid, push_ready;
  ssfr_pkg::entry_t push_entry;
  logic             pop_valid, pop_ready;
  ssfr_pkg::entry_t pop_entry;

  ssfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  ssfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  ssfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/ssfr_checker.sv =====
module ssfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input ssfr_pkg::in_item_t            in_item_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input ssfr_pkg::out_item_t           out_item_o,
  input logic                          cfg_we_i,
  input logic [ssfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [ssfr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // no data word means zeroed data fields
  a_no_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.data_valid |->
      out_item_o.data_word == '0 && out_item_o.data_index == '0 &&
      !out_item_o.frame_done)
    else $error("data fields set without a data word");

  // frame end leaves data phase with status done
  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |->
      out_item_o.data_valid && !out_item_o.in_data_phase &&
      out_item_o.status_now == ssfr_pkg::StDone)
    else $error("frame end with wrong phase or status");

  // data phase always runs with busy status
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.in_data_phase |->
      out_item_o.status_now == ssfr_pkg::StBusy)
    else $error("data phase without busy status");

  // data words are answered with busy
  a_data_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.data_valid |->
      out_item_o.reply_status == ssfr_pkg::StBusy)
    else $error("data word answered with wrong status");

endmodule

bind spi_slave_frame_receiver ssfr_checker u_ssfr_checker (.*);
